// ===== design/bfa_pkg.sv =====
// Shared types and constants of the bitmap first-fit chunk allocator.
`timescale 1ns / 1ps

package bfa_pkg;

    // Field widths of the request and response transactions
    localparam int REQ_W    = 21;   // request_bytes
    localparam int RSTART_W = 8;    // release_start
    localparam int CNT_W    = 9;    // release_count, chunk_count
    localparam int START_W  = 8;    // start_chunk
    localparam int OFF_W    = 20;   // byte_offset
    localparam int FREE_W   = 9;    // free_total and the free counter

    // Configuration register widths and reset values
    localparam int CB_W   = 13;     // chunk_bytes
    localparam int POOL_W = 9;      // pool_chunks
    localparam logic [CB_W-1:0]   CB_RESET   = 13'd64;
    localparam logic [POOL_W-1:0] POOL_RESET = 9'd256;

    // APB register file
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    typedef enum logic {
        REG_CHUNK_BYTES = 1'b0,
        REG_POOL_CHUNKS = 1'b1
    } t_reg_idx;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SPACE = 2'd1,
        ST_BAD      = 2'd2
    } t_status;

    // Result of the rounding divider
    typedef struct packed {
        logic             done;
        logic [REQ_W-1:0] quot;   // ceil(dividend / divisor)
    } t_div_res;

endpackage

// ===== design/bfa_if.sv =====
// Request and response channel interfaces of the chunk allocator.
`timescale 1ns / 1ps

interface bfa_req_if;
    import bfa_pkg::*;

    logic                valid;
    logic                ready;
    t_cmd                cmd;
    logic [REQ_W-1:0]    request_bytes;
    logic [RSTART_W-1:0] release_start;
    logic [CNT_W-1:0]    release_count;

    modport source (
        output valid, cmd, request_bytes, release_start, release_count,
        input  ready
    );
    modport sink (
        input  valid, cmd, request_bytes, release_start, release_count,
        output ready
    );
endinterface

interface bfa_rsp_if;
    import bfa_pkg::*;

    logic               valid;
    logic               ready;
    t_status            status;
    logic [START_W-1:0] start_chunk;
    logic [CNT_W-1:0]   chunk_count;
    logic [OFF_W-1:0]   byte_offset;
    logic [FREE_W-1:0]  free_total;

    modport source (
        output valid, status, start_chunk, chunk_count, byte_offset, free_total,
        input  ready
    );
    modport sink (
        input  valid, status, start_chunk, chunk_count, byte_offset, free_total,
        output ready
    );
endinterface

// ===== design/bfa_div.sv =====
// Radix-2 restoring divider that rounds the quotient up.
`timescale 1ns / 1ps

module bfa_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [bfa_pkg::REQ_W-1:0] i_dividend,
    input  logic [bfa_pkg::CB_W-1:0]  i_divisor,
    output bfa_pkg::t_div_res       o_res
);
    import bfa_pkg::*;

    localparam int STEP_W = $clog2(REQ_W);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [STEP_W-1:0] r_step, n_step;
    logic [CB_W-1:0]   r_rem,  n_rem;
    logic [REQ_W-1:0]  r_dvd,  n_dvd;
    logic [REQ_W-1:0]  r_quot, n_quot;
    logic [CB_W-1:0]   r_dvs,  n_dvs;

    logic [CB_W:0] w_shift;
    logic [CB_W:0] w_diff;
    logic          w_ge;

    assign w_shift = {r_rem, r_dvd[REQ_W-1]};
    assign w_diff  = w_shift - {1'b0, r_dvs};
    assign w_ge    = (w_shift >= {1'b0, r_dvs});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_quot = r_quot;
        n_dvs  = r_dvs;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = '0;
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_quot = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // one quotient bit per cycle, MSB first
            n_rem  = w_ge ? w_diff[CB_W-1:0] : w_shift[CB_W-1:0];
            n_quot = {r_quot[REQ_W-2:0], w_ge};
            n_dvd  = {r_dvd[REQ_W-2:0], 1'b0};
            if (r_step == STEP_W'(REQ_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_step = r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem  <= n_rem;
        r_dvd  <= n_dvd;
        r_quot <= n_quot;
        r_dvs  <= n_dvs;
    end

    // round up when a remainder is left
    assign o_res.done = r_done;
    assign o_res.quot = r_quot + REQ_W'(r_rem != '0);

endmodule

// ===== design/bitmap_first_fit_chunk_allocator_core.sv =====
// Top level of the bitmap first-fit chunk allocator.
`timescale 1ns / 1ps

// The allocator keeps one free bit per chunk in a 1-bit-wide memory of
// MAX_CHUNKS entries and serves one transaction at a time. An allocate
// transaction first rounds request_bytes up to whole chunks in a bit-serial
// divider, then walks the bitmap one chunk per cycle from chunk 0 looking for
// the lowest run of free chunks, clears the run one chunk per cycle and forms
// byte_offset in the multiply state. A free transaction sweeps its run with a
// read-then-set pipeline. Rejected requests go from idle straight through the
// multiply and done states, as do allocates rejected after the divide. The
// bitmap walk through the single memory read port sets the rate. After reset
// the memory is swept to all-free and the free counter is then rebuilt; a
// write to pool_chunks while idle or counting also rebuilds the counter. No
// request is taken during either sweep; APB writes are always taken. The
// result sits in an output register, so the next request can enter while the
// last result waits.
module bitmap_first_fit_chunk_allocator_core #(
    parameter int MAX_CHUNKS = 256
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // APB configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfa_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [bfa_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [bfa_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    // request and response channels
    bfa_req_if.sink                           i_req,
    bfa_rsp_if.source                         o_rsp
);
    import bfa_pkg::*;

    localparam int IW = $clog2(MAX_CHUNKS);           // chunk index
    localparam int CW = IW + 1;                       // count up to MAX_CHUNKS
    localparam int XW = (CW > POOL_W) ? CW : POOL_W;  // pool compare width
    localparam int EW = (CW > 10) ? CW : 10;          // release end compare width
    localparam int PW = IW + CB_W;                    // offset product width

    typedef enum logic [8:0] {
        S_CLEAR = 9'b000000001,
        S_COUNT = 9'b000000010,
        S_IDLE  = 9'b000000100,
        S_DIV   = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_MARK  = 9'b000100000,
        S_FREE  = 9'b001000000,
        S_MUL   = 9'b010000000,
        S_DONE  = 9'b100000000
    } t_state;

    // control state
    t_state            r_state, n_state;
    logic [CB_W-1:0]   r_chunk_bytes, n_chunk_bytes;
    logic [POOL_W-1:0] r_pool_chunks, n_pool_chunks;
    logic [CW-1:0]     r_addr, n_addr;     // read pointer or write pointer
    logic              r_chk_vld, n_chk_vld;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic [CW-1:0]     r_run, n_run;
    logic [CW-1:0]     r_need, n_need;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_out_vld, n_out_vld;

    // payload
    logic [CW-1:0]     r_chk, n_chk;       // address of the read data in flight
    t_status           r_status, n_status;
    logic [IW-1:0]     r_start, n_start;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [OFF_W-1:0]  r_offset;
    t_status           r_out_status;
    logic [START_W-1:0] r_out_start;
    logic [CNT_W-1:0]  r_out_count;
    logic [OFF_W-1:0]  r_out_offset;
    logic [FREE_W-1:0] r_out_free;

    // free bitmap
    logic              r_map [MAX_CHUNKS];
    logic              r_rd_data;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic              w_wdata;

    logic              w_wr;
    logic              w_wr_cb;
    logic              w_wr_pool;
    logic [XW-1:0]     w_pool_x;
    logic [CW-1:0]     w_pool_eff;
    logic              w_acc;
    logic              w_alloc_ok;
    logic [9:0]        w_rel_end;
    logic              w_rel_ok;
    logic              w_need_ok;
    logic              w_out_load;
    logic [PW-1:0]     w_prod;
    logic [CW-1:0]     w_found;
    t_div_res          w_div;

    // ---------------- APB register file ----------------
    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite;
    assign w_wr_cb   = w_wr && (t_reg_idx'(paddr[2]) == REG_CHUNK_BYTES);
    assign w_wr_pool = w_wr && (t_reg_idx'(paddr[2]) == REG_POOL_CHUNKS);

    always_comb begin
        unique case (t_reg_idx'(paddr[2]))
            REG_CHUNK_BYTES: prdata = APB_DATA_W'(r_chunk_bytes);
            REG_POOL_CHUNKS: prdata = APB_DATA_W'(r_pool_chunks);
            default:         prdata = '0;
        endcase
    end

    assign n_chunk_bytes = w_wr_cb   ? pwdata[CB_W-1:0]   : r_chunk_bytes;
    assign n_pool_chunks = w_wr_pool ? pwdata[POOL_W-1:0] : r_pool_chunks;

    // effective pool: min(pool_chunks, MAX_CHUNKS)
    assign w_pool_x   = (XW'(r_pool_chunks) < XW'(MAX_CHUNKS)) ?
                        XW'(r_pool_chunks) : XW'(MAX_CHUNKS);
    assign w_pool_eff = CW'(w_pool_x);

    // ---------------- request decode ----------------
    // hold off requests in the cycle that rewrites the pool size
    assign i_req.ready = (r_state == S_IDLE) && !w_wr_pool;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_alloc_ok  = (r_chunk_bytes != '0) && (i_req.request_bytes != '0);
    assign w_rel_end   = 10'(i_req.release_start) + 10'(i_req.release_count);
    assign w_rel_ok    = (i_req.release_count != '0) &&
                         (EW'(w_rel_end) <= EW'(w_pool_eff));
    assign w_need_ok   = (w_div.quot <= REQ_W'(w_pool_eff));
    // start of the run that completes at the chunk now read
    assign w_found     = r_chk + CW'(1) - r_need;

    bfa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_acc && (i_req.cmd == CMD_ALLOC) && w_alloc_ok),
        .i_dividend (i_req.request_bytes),
        .i_divisor  (r_chunk_bytes),
        .o_res      (w_div)
    );

    // ---------------- sequencer ----------------
    always_comb begin
        n_state    = r_state;
        n_addr     = r_addr;
        n_chk      = r_chk;
        n_chk_vld  = r_chk_vld;
        n_cnt      = r_cnt;
        n_run      = r_run;
        n_need     = r_need;
        n_free     = r_free;
        n_status   = r_status;
        n_start    = r_start;
        n_count    = r_count;
        n_out_vld  = r_out_vld;
        w_out_load = 1'b0;
        w_we       = 1'b0;
        w_waddr    = r_addr[IW-1:0];
        w_wdata    = 1'b0;

        // drop the result once the sink takes it
        if (r_out_vld && o_rsp.ready) begin
            n_out_vld = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // mark every chunk free, then rebuild the counter
                w_we    = 1'b1;
                w_wdata = 1'b1;
                n_addr  = r_addr + 1'b1;
                if (r_addr == CW'(MAX_CHUNKS - 1)) begin
                    n_state   = S_COUNT;
                    n_addr    = '0;
                    n_chk_vld = 1'b0;
                    n_free    = '0;
                end
            end

            S_COUNT: begin
                if (r_addr < w_pool_eff) begin
                    n_addr    = r_addr + 1'b1;
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld && r_rd_data) begin
                    n_free = r_free + 1'b1;
                end
                if (!r_chk_vld && (r_addr >= w_pool_eff)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (w_acc) begin
                    n_status = ST_BAD;
                    n_start  = '0;
                    n_count  = '0;
                    n_state  = S_MUL;
                    if (i_req.cmd == CMD_ALLOC) begin
                        if (w_alloc_ok) begin
                            n_state = S_DIV;
                        end
                    end else if (w_rel_ok) begin
                        n_status  = ST_OK;
                        n_start   = IW'(i_req.release_start);
                        n_count   = i_req.release_count;
                        n_addr    = CW'(i_req.release_start);
                        n_cnt     = CW'(i_req.release_count);
                        n_chk_vld = 1'b0;
                        n_state   = S_FREE;
                    end
                end
            end

            S_DIV: begin
                if (w_div.done) begin
                    if (w_need_ok) begin
                        n_need    = CW'(w_div.quot);
                        n_addr    = '0;
                        n_chk_vld = 1'b0;
                        n_run     = '0;
                        n_state   = S_SCAN;
                    end else begin
                        n_status = ST_BAD;
                        n_start  = '0;
                        n_count  = '0;
                        n_state  = S_MUL;
                    end
                end
            end

            S_SCAN: begin
                // issue one bitmap read per cycle and check its data in the cycle after
                if (r_addr < w_pool_eff) begin
                    n_addr    = r_addr + 1'b1;
                    n_chk     = r_addr;
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    if (r_rd_data) begin
                        if ((r_run + CW'(1)) == r_need) begin
                            n_status = ST_OK;
                            n_start  = IW'(w_found);
                            n_count  = CNT_W'(r_need);
                            n_free   = r_free - FREE_W'(r_need);
                            n_addr   = w_found;
                            n_cnt    = r_need;
                            n_state  = S_MARK;
                        end else begin
                            n_run = r_run + 1'b1;
                        end
                    end else begin
                        n_run = '0;
                    end
                end else if (r_addr >= w_pool_eff) begin
                    n_status = ST_NO_SPACE;
                    n_start  = '0;
                    n_count  = '0;
                    n_state  = S_MUL;
                end
            end

            S_MARK: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    n_state = S_MUL;
                end
            end

            S_FREE: begin
                // read each chunk, set it in the following cycle, count if it was used
                if (r_cnt != '0) begin
                    n_addr    = r_addr + 1'b1;
                    n_cnt     = r_cnt - 1'b1;
                    n_chk     = r_addr;
                    n_chk_vld = 1'b1;
                end else begin
                    n_chk_vld = 1'b0;
                end
                if (r_chk_vld) begin
                    w_we    = 1'b1;
                    w_waddr = r_chk[IW-1:0];
                    w_wdata = 1'b1;
                    if (!r_rd_data) begin
                        n_free = r_free + 1'b1;
                    end
                end
                if ((r_cnt == '0) && !r_chk_vld) begin
                    n_state = S_MUL;
                end
            end

            S_MUL: begin
                n_state = S_DONE;
            end

            S_DONE: begin
                // wait for the output register to be free
                if (!r_out_vld || o_rsp.ready) begin
                    w_out_load = 1'b1;
                    n_out_vld  = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a new pool size written while idle or counting restarts the free count
        if (w_wr_pool && ((r_state == S_IDLE) || (r_state == S_COUNT))) begin
            n_state   = S_COUNT;
            n_addr    = '0;
            n_chk_vld = 1'b0;
            n_free    = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_CLEAR;
            r_chunk_bytes <= CB_RESET;
            r_pool_chunks <= POOL_RESET;
            r_addr        <= '0;
            r_chk_vld     <= 1'b0;
            r_cnt         <= '0;
            r_run         <= '0;
            r_need        <= '0;
            r_free        <= '0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_chunk_bytes <= n_chunk_bytes;
            r_pool_chunks <= n_pool_chunks;
            r_addr        <= n_addr;
            r_chk_vld     <= n_chk_vld;
            r_cnt         <= n_cnt;
            r_run         <= n_run;
            r_need        <= n_need;
            r_free        <= n_free;
            r_out_vld     <= n_out_vld;
        end
    end

    // offset multiply: start chunk times chunk size
    assign w_prod = PW'(r_start) * PW'(r_chunk_bytes);

    always_ff @(posedge i_clk) begin
        r_chk    <= n_chk;
        r_status <= n_status;
        r_start  <= n_start;
        r_count  <= n_count;
        if (r_state == S_MUL) begin
            r_offset <= OFF_W'(w_prod);
        end
        if (w_out_load) begin
            r_out_status <= r_status;
            r_out_start  <= START_W'(r_start);
            r_out_count  <= r_count;
            r_out_offset <= r_offset;
            r_out_free   <= r_free;
        end
    end

    // bitmap memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_map[w_waddr] <= w_wdata;
        end
        r_rd_data <= r_map[r_addr[IW-1:0]];
    end

    assign o_rsp.valid       = r_out_vld;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.start_chunk = r_out_start;
    assign o_rsp.chunk_count = r_out_count;
    assign o_rsp.byte_offset = r_out_offset;
    assign o_rsp.free_total  = r_out_free;

`ifndef SYNTHESIS
    // the free counter never claims more chunks than the pool holds
    a_free_in_pool: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (XW'(r_free) <= XW'(w_pool_eff)))
        else $error("free counter exceeds pool size");

    // an accepted request always leaves the idle state
    a_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> (r_state != S_IDLE))
        else $error("request accepted but sequencer stayed idle");

    // the divider only finishes while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    // failed results carry no run
    a_fail_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status != ST_OK)) |->
        ((o_rsp.chunk_count == '0) && (o_rsp.byte_offset == '0) &&
         (o_rsp.start_chunk == '0)))
        else $error("failed result reports a run");
`endif

endmodule

// ===== sim/bitmap_first_fit_chunk_allocator_core_tb.sv =====
// Self-checking testbench for the bitmap first-fit chunk allocator core.
`timescale 1ns / 1ps

// The testbench drives allocate and free transactions into the core and keeps
// its own copy of the chunk bitmap, the free counter and both configuration
// registers. Every accepted request produces one expected response. The
// responses are checked field by field in arrival order. Directed tests cover
// the edges first. Random phases then run under several register settings,
// with bursty request traffic and a response sink that stalls on its own.
module bitmap_first_fit_chunk_allocator_core_tb;
    import bfa_pkg::*;

    localparam int NUM_CHUNKS = 256;        // matches the MAX_CHUNKS default
    localparam int MAX_REQ_BYTES = 1048576;

    typedef struct packed {
        t_status            status;
        logic [START_W-1:0] start_chunk;
        logic [CNT_W-1:0]   chunk_count;
        logic [OFF_W-1:0]   byte_offset;
        logic [FREE_W-1:0]  free_total;
    } alloc_result_t;

    typedef struct {
        int unsigned first;
        int unsigned len;
    } chunk_run_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    bitmap_first_fit_chunk_allocator_core #(
        .MAX_CHUNKS (NUM_CHUNKS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Shadow state of the allocator
    logic [NUM_CHUNKS-1:0] shadow_free_map;
    logic [FREE_W-1:0]     shadow_free_count;
    logic [CB_W-1:0]       shadow_chunk_bytes;
    logic [POOL_W-1:0]     shadow_pool_chunks;

    alloc_result_t pending_results[$];   // expected responses, oldest first
    chunk_run_t    granted_runs[$];      // runs handed out and not yet returned

    int mismatch_count = 0;
    int response_count = 0;
    int rsp_hold_cycles = 0;     // long sink hold-off, counted down by the sink
    int burst_left = 1;
    bit request_gaps = 1'b1;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Limit: far beyond the slowest correct run
    initial begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    function automatic int unsigned effective_pool();
        return (shadow_pool_chunks < NUM_CHUNKS) ? shadow_pool_chunks : NUM_CHUNKS;
    endfunction

    // Count free chunks below the pool boundary.
    function automatic void recount_free_chunks();
        int unsigned total;
        total = 0;
        for (int i = 0; i < effective_pool(); i++)
            total += shadow_free_map[i];
        shadow_free_count = FREE_W'(total);
    endfunction

    function automatic bit run_all_free(int unsigned first, int unsigned len);
        for (int unsigned k = 0; k < len; k++)
            if (!shadow_free_map[first + k])
                return 1'b0;
        return 1'b1;
    endfunction

    // Apply one request to the shadow state and return the response it earns.
    function automatic alloc_result_t predict_allocation(t_cmd cmd, int unsigned nbytes,
                                                         int unsigned rel_start,
                                                         int unsigned rel_count);
        alloc_result_t res;
        int unsigned pool;
        int unsigned need;
        int unsigned first;
        int unsigned len;
        chunk_run_t run;
        pool = effective_pool();
        first = 0;
        len = 0;
        res.status = ST_BAD;
        if (cmd == CMD_ALLOC) begin
            if (shadow_chunk_bytes != 0 && nbytes != 0) begin
                need = (nbytes + shadow_chunk_bytes - 1) / shadow_chunk_bytes;
                if (need <= pool) begin
                    res.status = ST_NO_SPACE;
                    // plain first fit: lowest start with a fully free run
                    for (int unsigned i = 0; i + need <= pool; i++) begin
                        if (run_all_free(i, need)) begin
                            for (int unsigned k = 0; k < need; k++)
                                shadow_free_map[i + k] = 1'b0;
                            shadow_free_count = shadow_free_count - FREE_W'(need);
                            res.status = ST_OK;
                            first = i;
                            len = need;
                            run.first = i;
                            run.len = need;
                            granted_runs.push_back(run);
                            break;
                        end
                    end
                end
            end
        end else if (rel_count != 0 && rel_start + rel_count <= pool) begin
            // only chunks that were in use raise the counter
            for (int unsigned k = 0; k < rel_count; k++) begin
                if (!shadow_free_map[rel_start + k]) begin
                    shadow_free_map[rel_start + k] = 1'b1;
                    shadow_free_count = shadow_free_count + 1'b1;
                end
            end
            res.status = ST_OK;
            first = rel_start;
            len = rel_count;
        end
        res.start_chunk = START_W'(first);
        res.chunk_count = CNT_W'(len);
        res.byte_offset = OFF_W'(first * shadow_chunk_bytes);
        res.free_total = shadow_free_count;
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(string field, longint unsigned got,
                                   longint unsigned exp_val);
        $display("[%0t] response %0d: %s is %0d, expected %0d",
                 $realtime, response_count, field, got, exp_val);
        mismatch_count++;
    endtask

    // Compare each response transaction with the oldest expectation.
    always @(posedge i_clk) begin
        alloc_result_t exp_res;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
                $display("[%0t] response %0d arrived with nothing expected",
                         $realtime, response_count);
                mismatch_count++;
            end else begin
                exp_res = pending_results.pop_front();
                if (rsp_ch.status !== exp_res.status)
                    report_mismatch("status", rsp_ch.status, exp_res.status);
                if (rsp_ch.start_chunk !== exp_res.start_chunk)
                    report_mismatch("start_chunk", rsp_ch.start_chunk, exp_res.start_chunk);
                if (rsp_ch.chunk_count !== exp_res.chunk_count)
                    report_mismatch("chunk_count", rsp_ch.chunk_count, exp_res.chunk_count);
                if (rsp_ch.byte_offset !== exp_res.byte_offset)
                    report_mismatch("byte_offset", rsp_ch.byte_offset, exp_res.byte_offset);
                if (rsp_ch.free_total !== exp_res.free_total)
                    report_mismatch("free_total", rsp_ch.free_total, exp_res.free_total);
            end
            response_count++;
        end
    end

    // Response sink: honor a long hold-off when one is asked for, else stall
    // on a pattern that is picked anew at random intervals.
    initial begin
        int mode;
        int mode_left;
        int phase_cnt;
        mode = 0;
        mode_left = 40;
        phase_cnt = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rsp_hold_cycles > 0) begin
                rsp_ch.ready <= 1'b0;
                rsp_hold_cycles--;
            end else begin
                case (mode)
                    0: rsp_ch.ready <= 1'b1;
                    1: rsp_ch.ready <= ($urandom_range(0, 3) != 0);
                    2: rsp_ch.ready <= ((phase_cnt % 5) < 2);
                    default: rsp_ch.ready <= ($urandom_range(0, 1) != 0);
                endcase
                phase_cnt++;
                if (--mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one request and hold it until the core takes it; then record the
    // expected response and, at the end of a burst, drop valid for a gap.
    task automatic send_request(t_cmd cmd, int unsigned nbytes,
                                int unsigned rel_start, int unsigned rel_count);
        int gap;
        @(negedge i_clk);
        req_ch.valid         <= 1'b1;
        req_ch.cmd           <= cmd;
        req_ch.request_bytes <= REQ_W'(nbytes);
        req_ch.release_start <= RSTART_W'(rel_start);
        req_ch.release_count <= CNT_W'(rel_count);
        do @(posedge i_clk); while (!req_ch.ready);
        pending_results.push_back(predict_allocation(cmd, nbytes, rel_start, rel_count));
        if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
            if (request_gaps && gap > 0) begin
                @(negedge i_clk);
                req_ch.valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    endtask

    task automatic alloc_bytes(int unsigned nbytes);
        send_request(CMD_ALLOC, nbytes, $urandom_range(0, 255), $urandom_range(0, 256));
    endtask

    task automatic free_run(int unsigned first, int unsigned len);
        send_request(CMD_FREE, $urandom_range(0, MAX_REQ_BYTES), first, len);
    endtask

    // Drop valid and hold until every expected response has come back.
    task automatic wait_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
    endtask

    // Write one register over APB, then read it back.
    task automatic set_register(t_reg_idx idx, int unsigned value);
        logic [APB_DATA_W-1:0] readback;
        wait_drained();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (idx == REG_CHUNK_BYTES) begin
            shadow_chunk_bytes = CB_W'(value);
        end else begin
            shadow_pool_chunks = POOL_W'(value);
            recount_free_chunks();
        end
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        readback = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== ((idx == REG_CHUNK_BYTES) ? APB_DATA_W'(shadow_chunk_bytes)
                                                   : APB_DATA_W'(shadow_pool_chunks)))
            report_mismatch(idx == REG_CHUNK_BYTES ? "chunk_bytes readback"
                                                   : "pool_chunks readback",
                            readback, (idx == REG_CHUNK_BYTES) ? shadow_chunk_bytes
                                                               : shadow_pool_chunks);
    endtask

    // Bytes that round up to exactly the given chunk count.
    function automatic int unsigned bytes_for_chunks(int unsigned chunks);
        if (shadow_chunk_bytes == 0)
            return $urandom_range(0, MAX_REQ_BYTES);
        return (chunks - 1) * shadow_chunk_bytes + $urandom_range(1, shadow_chunk_bytes);
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, rejects, first fit into a hole, full pool.
    task automatic test_alloc_free_edges();
        alloc_bytes(0);                 // zero-size allocate
        alloc_bytes(1);                 // chunk 0
        alloc_bytes(64);                // chunk 1, exact fit
        alloc_bytes(65);                // rounds up to two chunks
        alloc_bytes(MAX_REQ_BYTES);     // larger than the pool
        alloc_bytes(16384);             // whole pool while some is used
        free_run(0, 0);                 // zero-length free
        free_run(255, 2);               // run past the pool end
        free_run(1, 1);
        free_run(1, 1);                 // already free, counter holds
        alloc_bytes(64);                // lands in the hole at chunk 1
        free_run(0, 256);
        alloc_bytes(16384);             // whole pool
        alloc_bytes(1);                 // nothing left
        free_run(128, 128);
        alloc_bytes(8192);              // upper half again
        alloc_bytes(MAX_REQ_BYTES - 1);
        free_run(0, 256);
        wait_drained();
    endtask

    // Shrink the pool over used chunks and grow it back.
    task automatic test_pool_resize();
        alloc_bytes(200 * 64);
        set_register(REG_POOL_CHUNKS, 100);
        alloc_bytes(64);                // no free chunk below the boundary
        free_run(150, 10);              // beyond the shrunk pool
        free_run(90, 10);
        set_register(REG_POOL_CHUNKS, 256);
        free_run(0, 256);
        wait_drained();
    endtask

    // A zero chunk size rejects allocates but frees still work.
    task automatic test_zero_chunk_size();
        set_register(REG_CHUNK_BYTES, 0);
        alloc_bytes(1);
        alloc_bytes(MAX_REQ_BYTES);
        free_run(3, 1);
        set_register(REG_CHUNK_BYTES, 64);
        wait_drained();
    endtask

    // Hold the sink off long enough that the core fills up and stalls its
    // request side while requests keep being offered.
    task automatic test_response_backpressure();
        @(posedge i_clk);
        rsp_hold_cycles = 400;
        for (int i = 0; i < 8; i++)
            alloc_bytes(bytes_for_chunks($urandom_range(1, 4)));
        free_run(0, 256);
        wait_drained();
    endtask

    // Mostly well-formed traffic: allocations and the return of granted runs,
    // with some malformed and overlapping requests mixed in.
    task automatic run_random_mix(int items);
        int unsigned pool;
        int unsigned need;
        int pick;
        int sel;
        chunk_run_t run;
        granted_runs.delete();
        for (int n = 0; n < items; n++) begin
            pool = effective_pool();
            sel = $urandom_range(0, 99);
            if (sel < 55) begin
                pick = $urandom_range(0, 19);
                if (pick < 16)
                    need = $urandom_range(1, (pool < 8) ? pool : 8);
                else if (pick < 19)
                    need = $urandom_range(1, pool);
                else
                    need = pool;
                alloc_bytes(bytes_for_chunks(need));
            end else if (sel < 87 && granted_runs.size() != 0) begin
                pick = $urandom_range(0, granted_runs.size() - 1);
                run = granted_runs[pick];
                granted_runs.delete(pick);
                if ($urandom_range(0, 9) == 0)
                    free_run(run.first, run.len + $urandom_range(1, 3));
                else
                    free_run(run.first, run.len);
            end else begin
                case ($urandom_range(0, 3))
                    0: alloc_bytes(0);
                    1: alloc_bytes($urandom_range(0, MAX_REQ_BYTES));
                    default: free_run($urandom_range(0, 255), $urandom_range(0, 256));
                endcase
            end
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end
        wait_drained();
    endtask

    task automatic test_random_phases();
        set_register(REG_CHUNK_BYTES, 64);
        set_register(REG_POOL_CHUNKS, 256);
        run_random_mix(150);

        set_register(REG_CHUNK_BYTES, 1);
        set_register(REG_POOL_CHUNKS, 1);
        run_random_mix(60);

        set_register(REG_CHUNK_BYTES, 4096);
        set_register(REG_POOL_CHUNKS, 256);
        run_random_mix(150);

        set_register(REG_CHUNK_BYTES, $urandom_range(2, 4095));
        set_register(REG_POOL_CHUNKS, $urandom_range(2, 255));
        run_random_mix(150);

        // long stretch without request gaps
        request_gaps = 1'b0;
        set_register(REG_CHUNK_BYTES, 1);
        set_register(REG_POOL_CHUNKS, 256);
        run_random_mix(120);
        request_gaps = 1'b1;

        set_register(REG_CHUNK_BYTES, $urandom_range(1, 4096));
        set_register(REG_POOL_CHUNKS, $urandom_range(1, 256));
        run_random_mix(120);
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n              = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        req_ch.valid         = 1'b0;
        req_ch.cmd           = CMD_ALLOC;
        req_ch.request_bytes = '0;
        req_ch.release_start = '0;
        req_ch.release_count = '0;
        shadow_chunk_bytes   = CB_RESET;
        shadow_pool_chunks   = POOL_RESET;
        shadow_free_map      = '1;
        recount_free_chunks();

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_alloc_free_edges();
        test_pool_resize();
        test_zero_chunk_size();
        test_response_backpressure();
        test_random_phases();

        wait_drained();
        repeat (600) @(posedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
